>>> rtl/mwpo_pkg.sv
package mwpo_pkg;

  // Default sizes handed to the top level.
  localparam int PHASE_BITS_DEF      = 32;
  localparam int SINE_TABLE_BITS_DEF = 10;
  localparam int SAMPLE_BITS_DEF     = 16;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int STEP_W     = 32;
  localparam int GAIN_W     = 17;

  // Waveform values are signed Q30 in [-1, +1]; they need 32 bits.
  localparam int WAVE_W = 32;
  // Product of a Q30 value and an unsigned 17-bit gain, with margin.
  localparam int PROD_W = 50;

  localparam logic signed [WAVE_W-1:0] UNIT_Q30 = 32'sh4000_0000;
  localparam logic signed [WAVE_W-1:0] HALF_Q30 = 32'sh2000_0000;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_TRIANGLE = 2'd1,
    WAVE_SQUARE   = 2'd2,
    WAVE_SAW      = 2'd3
  } waveform_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WAVEFORM   = 2'd0,
    CFG_PHASE_STEP = 2'd1,
    CFG_GAIN       = 2'd2
  } cfg_reg_t;

  // One sine table entry in Q30, evaluated at elaboration time.
  // A Taylor series up to the x^17 term over a quarter wave, mirrored
  // and negated by quadrant. The quarter size is a power of two, so the
  // scaling of the quarter-wave index is a shift.
  function automatic logic signed [WAVE_W-1:0] sine_entry(input int unsigned idx,
                                                          input int unsigned tbits);
    logic [63:0]        quarter;
    logic [63:0]        quad;
    logic [63:0]        r;
    logic [63:0]        k;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        t;
    logic signed [63:0] sum;
    quarter = 64'd1 << (tbits - 2);
    quad    = 64'(idx) >> (tbits - 2);
    r       = 64'(idx) & (quarter - 64'd1);
    k       = quad[0] ? (quarter - r) : r;
    x       = (k * HALF_PI_Q30) >> (tbits - 2);
    x2      = (x * x) >> 30;
    t       = x;
    sum     = $signed(x);
    t = ((t * x2) >> 30) / 64'd6;   sum = sum - $signed(t);
    t = ((t * x2) >> 30) / 64'd20;  sum = sum + $signed(t);
    t = ((t * x2) >> 30) / 64'd42;  sum = sum - $signed(t);
    t = ((t * x2) >> 30) / 64'd72;  sum = sum + $signed(t);
    t = ((t * x2) >> 30) / 64'd110; sum = sum - $signed(t);
    t = ((t * x2) >> 30) / 64'd156; sum = sum + $signed(t);
    t = ((t * x2) >> 30) / 64'd210; sum = sum - $signed(t);
    t = ((t * x2) >> 30) / 64'd272; sum = sum + $signed(t);
    if (sum < 64'sd0) begin
      sum = 64'sd0;
    end
    if (sum > 64'sd1073741824) begin
      sum = 64'sd1073741824;
    end
    if (quad[1]) begin
      sum = -sum;
    end
    return sum[WAVE_W-1:0];
  endfunction

endpackage

>>> rtl/mwpo_sine_rom.sv
module mwpo_sine_rom import mwpo_pkg::*; #(
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [SINE_TABLE_BITS-1:0] rd_addr,
  output logic signed [WAVE_W-1:0]   rd_data_r
);

  localparam int ROM_SIZE = 1 << SINE_TABLE_BITS;

  logic signed [WAVE_W-1:0] rom_tbl [ROM_SIZE];

  // Table contents are fixed at elaboration.
  for (genvar i = 0; i < ROM_SIZE; i++) begin : g_fill
    assign rom_tbl[i] = sine_entry(i, SINE_TABLE_BITS);
  end

  // Registered read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= rom_tbl[rd_addr];
    end
  end

endmodule

>>> rtl/mwpo_shaper.sv
module mwpo_shaper import mwpo_pkg::*; #(
  parameter int PHASE_BITS = PHASE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     en,
  input  waveform_t                waveform,
  input  logic [PHASE_BITS-1:0]    phase,
  input  logic signed [WAVE_W-1:0] rom_data,
  input  logic [GAIN_W-1:0]        gain,
  output logic signed [PROD_W-1:0] prod_r
);

  logic [PHASE_BITS+29:0]     phase_ext;
  logic [29:0]                frac;
  logic signed [WAVE_W-1:0]   frac_s;
  logic signed [WAVE_W-1:0]   centered;
  logic signed [WAVE_W-1:0]   mag;
  logic signed [WAVE_W-1:0]   wave_val;
  logic signed [GAIN_W:0]     gain_s;
  logic signed [PROD_W-1:0]   prod_nxt;

  // Top 30 fraction bits of the phase, zero-filled on the right.
  assign phase_ext = {phase, 30'd0};
  assign frac      = phase_ext[PHASE_BITS+29 -: 30];
  assign frac_s    = $signed({2'b00, frac});
  assign centered  = frac_s - HALF_Q30;
  assign mag       = (centered < 0) ? -centered : centered;

  // Waveform value in Q30.
  always_comb begin
    case (waveform)
      WAVE_SINE: begin
        wave_val = rom_data;
      end
      WAVE_TRIANGLE: begin
        wave_val = UNIT_Q30 - (mag <<< 2);
      end
      WAVE_SQUARE: begin
        wave_val = ((phase != '0) && !phase[PHASE_BITS-1]) ? UNIT_Q30 : -UNIT_Q30;
      end
      default: begin
        wave_val = centered <<< 1;
      end
    endcase
  end

  // Volume scaling.
  assign gain_s   = $signed({1'b0, gain});
  assign prod_nxt = PROD_W'(wave_val) * PROD_W'(gain_s);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

>>> rtl/mwpo_round_sat.sv
module mwpo_round_sat import mwpo_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [PROD_W-1:0]      prod,
  output logic signed [SAMPLE_BITS-1:0] sample_r
);

  localparam int SH = 47 - SAMPLE_BITS;
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(64'd1 << (SH - 1));
  localparam logic signed [PROD_W-1:0] MAX_VAL    = PROD_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [PROD_W-1:0] MIN_VAL    = PROD_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

  logic signed [PROD_W-1:0]      rounded;
  logic signed [PROD_W-1:0]      shifted;
  logic signed [SAMPLE_BITS-1:0] sample_nxt;

  // Round half up, then floor by an arithmetic shift.
  assign rounded = prod + ROUND_HALF;
  assign shifted = rounded >>> SH;

  // Saturate to the signed output range.
  always_comb begin
    if (shifted > MAX_VAL) begin
      sample_nxt = MAX_VAL[SAMPLE_BITS-1:0];
    end else if (shifted < MIN_VAL) begin
      sample_nxt = MIN_VAL[SAMPLE_BITS-1:0];
    end else begin
      sample_nxt = shifted[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sample_r <= sample_nxt;
    end
  end

endmodule

>>> rtl/multi_waveform_phase_oscillator_core.sv
// Channel   Direction  Handshake             Payload
// cfg       in         cfg_we                cfg_index, cfg_data
// in        in         in_valid / in_stall   in_restart
// out       out        out_valid / out_stall out_sample
//
// One sample per clock cycle sustained while the output is not stalled; each
// transaction passes three register stages (sine table read and phase register,
// gain multiply, rounding and saturation) before it shows on the output.
// The phase accumulator add is the only loop.
// Reset is synchronous and clears the phase, config and valid registers only.
// A stall on the output only stops the stages that hold data; bubbles still fill.
module multi_waveform_phase_oscillator_core import mwpo_pkg::*; #(
  parameter int PHASE_BITS      = PHASE_BITS_DEF,
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
  parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_restart,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_sample
);

  waveform_t                waveform_r;
  logic [STEP_W-1:0]        step_r;
  logic [GAIN_W-1:0]        gain_r;
  logic [PHASE_BITS-1:0]    phase_acc_r;
  logic [PHASE_BITS-1:0]    phase1_r;
  logic                     v1_r;
  logic                     v2_r;
  logic                     out_valid_r;

  logic [PHASE_BITS+STEP_W-1:0] step_ext;
  logic [PHASE_BITS-1:0]        step_eff;
  logic [PHASE_BITS-1:0]        cur_phase;
  logic                         in_acc;
  logic                         ld1;
  logic                         ld2;
  logic                         ld3;
  logic signed [WAVE_W-1:0]     rom_q;
  logic signed [PROD_W-1:0]     prod;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waveform_r <= WAVE_SINE;
      step_r     <= '0;
      gain_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WAVEFORM:   waveform_r <= waveform_t'(cfg_data[1:0]);
        CFG_PHASE_STEP: step_r     <= cfg_data[STEP_W-1:0];
        CFG_GAIN:       gain_r     <= cfg_data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Pipeline advance: a stage loads when it is empty or its successor loads.
  assign ld3      = !out_valid_r || !out_stall;
  assign ld2      = !v2_r || ld3;
  assign ld1      = !v1_r || ld2;
  assign in_stall = !ld1;
  assign in_acc   = in_valid && ld1;

  // Phase accumulator; the sample uses the phase before the step.
  assign step_ext  = {{PHASE_BITS{1'b0}}, step_r};
  assign step_eff  = step_ext[PHASE_BITS-1:0];
  assign cur_phase = in_restart ? '0 : phase_acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_acc_r <= '0;
    end else if (in_acc) begin
      phase_acc_r <= cur_phase + step_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      phase1_r <= cur_phase;
    end
  end

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ld1) begin
        v1_r <= in_valid;
      end
      if (ld2) begin
        v2_r <= v1_r;
      end
      if (ld3) begin
        out_valid_r <= v2_r;
      end
    end
  end

  mwpo_sine_rom #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_rom (
    .clk      (clk),
    .rd_en    (in_acc),
    .rd_addr  (cur_phase[PHASE_BITS-1 -: SINE_TABLE_BITS]),
    .rd_data_r(rom_q)
  );

  mwpo_shaper #(
    .PHASE_BITS(PHASE_BITS)
  ) u_shaper (
    .clk     (clk),
    .en      (ld2 && v1_r),
    .waveform(waveform_r),
    .phase   (phase1_r),
    .rom_data(rom_q),
    .gain    (gain_r),
    .prod_r  (prod)
  );

  mwpo_round_sat #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_round (
    .clk     (clk),
    .en      (ld3 && v2_r),
    .prod    (prod),
    .sample_r(out_sample)
  );

  assign out_valid = out_valid_r;

endmodule

>>> tb/sv/multi_waveform_phase_oscillator_core_tb.sv
`timescale 1ns / 1ps

module multi_waveform_phase_oscillator_core_tb;
  import mwpo_pkg::*;

  localparam int          PIPE_LAT     = 4;
  localparam int          HOLD_CYCLES  = 80;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          RAND_PHASES  = 20;
  localparam int          PHASE_TICKS  = 85;
  localparam int          DIR_ROWS     = 25;
  localparam logic [63:0] QUARTER_TURN = 64'd1686629713;
  localparam longint      ONE_Q30      = 64'sd1 <<< 30;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;
  localparam logic [31:0]          GAIN_UNITY  = 32'h0001_0000;
  localparam logic [31:0]          GAIN_MAX    = 32'h0001_FFFF;
  localparam logic [31:0]          STEP_HALF   = 32'h8000_0000;
  localparam logic [31:0]          STEP_QUART  = 32'h4000_0000;
  localparam logic signed [15:0]   SAMPLE_MIN  = 16'sh8000;
  localparam logic signed [15:0]   SAMPLE_MAX  = 16'sh7FFF;

  // One directed tick: register values as written, restart, and an optional
  // hand-typed sample.
  typedef struct {
    logic [31:0]        wave_raw;
    logic [31:0]        step_raw;
    logic [31:0]        gain_raw;
    logic               restart;
    bit                 typed;
    logic signed [15:0] sample;
  } tick_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_stall;
  logic                   in_restart;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic signed [15:0]     out_sample;

  // Oscillator shadow state for prediction.
  waveform_t              osc_wave;
  logic [31:0]            osc_step;
  logic [16:0]            osc_gain;
  logic [31:0]            osc_phase;
  longint                 sine_tab [0:1023];

  logic signed [15:0]     sample_q [$];
  logic signed [15:0]     want_sample;
  tick_row_t              dir_table [0:DIR_ROWS-1];
  int                     fail_cnt = 0;
  int                     cycle_cnt = 0;
  int                     send_idle_pct = 0;
  int                     recv_stall_pct = 0;
  int                     hold_asked = 0;
  int                     hold_done = 0;
  int                     hold_left = 0;

  multi_waveform_phase_oscillator_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_restart (in_restart),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_sample (out_sample)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Quarter-wave sine in Q30 by a truncated Taylor series up to x^17.
  function automatic longint quarter_wave(input longint unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint          acc;
    int              n;
    x   = (k * QUARTER_TURN) / 64'd256;
    x2  = (x * x) >> 30;
    t   = x;
    acc = longint'(x);
    for (n = 3; n <= 17; n += 2) begin
      t = ((t * x2) >> 30) / longint'((n - 1) * n);
      if (n[1]) begin
        acc = acc - longint'(t);
      end else begin
        acc = acc + longint'(t);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > ONE_Q30) begin
      acc = ONE_Q30;
    end
    return acc;
  endfunction

  // Register write as seen by the oscillator; unknown indexes are ignored.
  function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [31:0] data);
    case (idx)
      CFG_WAVEFORM: begin
        osc_wave = waveform_t'(data[1:0]);
      end
      CFG_PHASE_STEP: begin
        osc_step = data;
      end
      CFG_GAIN: begin
        osc_gain = data[16:0];
      end
      default: begin
      end
    endcase
  endfunction

  // Sample for one tick at the current phase, then advance the phase.
  function automatic logic signed [15:0] next_sample(input logic restart);
    longint wave_q30;
    longint frac;
    longint dev;
    longint prod;
    longint scaled;
    if (restart) begin
      osc_phase = '0;
    end
    frac = longint'(osc_phase[31:2]);
    case (osc_wave)
      WAVE_SINE: begin
        wave_q30 = sine_tab[osc_phase[31:22]];
      end
      WAVE_TRIANGLE: begin
        dev = frac - ONE_Q30 / 2;
        if (dev < 0) begin
          dev = -dev;
        end
        wave_q30 = ONE_Q30 - 4 * dev;
      end
      WAVE_SQUARE: begin
        wave_q30 = (osc_phase != 0 && !osc_phase[31]) ? ONE_Q30 : -ONE_Q30;
      end
      default: begin
        wave_q30 = 2 * frac - ONE_Q30;
      end
    endcase
    prod   = wave_q30 * longint'(osc_gain);
    scaled = (prod + (64'sd1 <<< 30)) >>> 31;
    if (scaled > 32767) begin
      scaled = 32767;
    end
    if (scaled < -32768) begin
      scaled = -32768;
    end
    osc_phase = osc_phase + osc_step;
    return scaled[15:0];
  endfunction

  // Offer one tick, wait for its transaction, and record the expected sample.
  task automatic send_tick(input logic restart, input bit typed,
                           input logic signed [15:0] typed_sample);
    logic signed [15:0] predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (in_stall);
    predicted = next_sample(restart);
    sample_q.push_back(typed ? typed_sample : predicted);
  endtask

  // Stop offering and wait until every expected sample has come out.
  task automatic drain_results;
    @(negedge clk);
    in_valid <= 1'b0;
    while (sample_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (PIPE_LAT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    apply_cfg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_done) begin
      hold_done <= hold_asked;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Compare each output transaction with the oldest expected sample.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (sample_q.size() == 0) begin
        $error("sample with nothing expected: actual %0d", out_sample);
        fail_cnt++;
      end else begin
        want_sample = sample_q.pop_front();
        if (out_sample !== want_sample) begin
          $error("sample mismatch: expected %0d, actual %0d", want_sample, out_sample);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    logic [31:0] cur_raw [0:2];
    logic [31:0] row_raw [0:2];
    logic [31:0] step_val;
    logic [31:0] gain_val;
    int          wave_sel;
    int          i;
    int          r;
    int          ph;

    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    in_restart = 1'b0;
    osc_wave   = WAVE_SINE;
    osc_step   = '0;
    osc_gain   = '0;
    osc_phase  = '0;

    // Full-cycle sine table, mirrored and negated by quadrant.
    for (i = 0; i < 1024; i++) begin
      r = i & 255;
      sine_tab[i] = (i & 256) ? quarter_wave(256 - r) : quarter_wave(r);
      if (i & 512) begin
        sine_tab[i] = -sine_tab[i];
      end
    end

    dir_table = '{
      // Reset state gives silence; at phase zero saw, square and triangle sit at negative full scale.
      '{32'(WAVE_SINE),     32'd0,         32'd0,        1'b0, 1'b1, 16'sd0},
      '{32'(WAVE_SAW),      32'd0,         GAIN_UNITY,   1'b1, 1'b1, SAMPLE_MIN},
      '{32'(WAVE_SQUARE),   32'd0,         GAIN_UNITY,   1'b0, 1'b1, SAMPLE_MIN},
      '{32'(WAVE_TRIANGLE), 32'd0,         GAIN_UNITY,   1'b0, 1'b1, SAMPLE_MIN},
      // Triangle peak at half a cycle saturates to full scale.
      '{32'(WAVE_TRIANGLE), STEP_HALF,     GAIN_UNITY,   1'b1, 1'b1, SAMPLE_MIN},
      '{32'(WAVE_TRIANGLE), STEP_HALF,     GAIN_UNITY,   1'b0, 1'b1, SAMPLE_MAX},
      // Shape change keeps the phase; upper data bits are dropped.
      '{32'hFFFF_FFFE,      STEP_HALF,     32'hFFFF_0000, 1'b0, 1'b1, SAMPLE_MIN},
      '{32'hFFFF_FFFE,      STEP_HALF,     32'hFFFF_0000, 1'b0, 1'b1, SAMPLE_MIN},
      // Square is high only strictly inside the first half cycle.
      '{32'(WAVE_SQUARE),   32'd1,         GAIN_UNITY,   1'b1, 1'b1, SAMPLE_MIN},
      '{32'(WAVE_SQUARE),   32'd1,         GAIN_UNITY,   1'b0, 1'b1, SAMPLE_MAX},
      '{32'(WAVE_SAW),      32'hFFFF_FFFF, GAIN_UNITY,   1'b1, 1'b1, SAMPLE_MIN},
      '{32'(WAVE_SAW),      32'hFFFF_FFFF, GAIN_UNITY,   1'b0, 1'b0, 16'sd0},
      '{32'(WAVE_SINE),     STEP_QUART,    GAIN_UNITY,   1'b1, 1'b1, 16'sd0},
      '{32'(WAVE_SINE),     STEP_QUART,    GAIN_UNITY,   1'b0, 1'b0, 16'sd0},
      '{32'(WAVE_SINE),     STEP_QUART,    GAIN_UNITY,   1'b0, 1'b0, 16'sd0},
      '{32'(WAVE_SINE),     STEP_QUART,    GAIN_UNITY,   1'b0, 1'b0, 16'sd0},
      // Gain above unity amplifies and saturates.
      '{32'(WAVE_SINE),     32'h1000_3039, GAIN_MAX,     1'b1, 1'b0, 16'sd0},
      '{32'(WAVE_SINE),     32'h1000_3039, GAIN_MAX,     1'b0, 1'b0, 16'sd0},
      '{32'(WAVE_SINE),     32'h1000_3039, GAIN_MAX,     1'b0, 1'b0, 16'sd0},
      '{32'(WAVE_SAW),      32'h2000_0000, GAIN_MAX,     1'b1, 1'b1, SAMPLE_MIN},
      '{32'(WAVE_SAW),      32'h2000_0000, GAIN_MAX,     1'b0, 1'b0, 16'sd0},
      '{32'(WAVE_TRIANGLE), 32'h1234_5678, 32'd0,        1'b1, 1'b1, 16'sd0},
      '{32'(WAVE_TRIANGLE), 32'd1234,      GAIN_MAX,     1'b0, 1'b0, 16'sd0},
      '{32'(WAVE_SINE),     32'hFFFF_FFFF, 32'd65535,    1'b0, 1'b0, 16'sd0},
      '{32'(WAVE_SQUARE),   32'd0,         32'd1,        1'b0, 1'b0, 16'sd0}
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // A write to an unused index must leave every register alone.
    write_reg(CFG_SPARE, 32'hFFFF_FFFF);

    // Directed ticks; registers are rewritten only between drained stretches.
    cur_raw = '{32'd0, 32'd0, 32'd0};
    for (i = 0; i < DIR_ROWS; i++) begin
      row_raw = '{dir_table[i].wave_raw, dir_table[i].step_raw, dir_table[i].gain_raw};
      if (row_raw != cur_raw) begin
        drain_results;
        if (row_raw[0] != cur_raw[0]) begin
          write_reg(CFG_WAVEFORM, row_raw[0]);
        end
        if (row_raw[1] != cur_raw[1]) begin
          write_reg(CFG_PHASE_STEP, row_raw[1]);
        end
        if (row_raw[2] != cur_raw[2]) begin
          write_reg(CFG_GAIN, row_raw[2]);
        end
        cur_raw = row_raw;
      end
      send_tick(dir_table[i].restart, dir_table[i].typed, dir_table[i].sample);
    end

    // Random phases: new settings each time, rotating through idle patterns.
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      drain_results;
      case (ph % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 78;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 78;
        end
        default: begin
          send_idle_pct  = 17;
          recv_stall_pct = 17;
        end
      endcase
      wave_sel = (ph < 4) ? ph : $urandom_range(3);
      case ($urandom_range(5))
        0: step_val = 32'd0;
        1: step_val = 32'hFFFF_FFFF;
        2: step_val = $urandom_range(1, 1 << 20);
        3: step_val = 32'hFFFF_FFFF / $urandom_range(2, 64);
        default: step_val = $urandom();
      endcase
      case ($urandom_range(4))
        0: gain_val = 32'd0;
        1: gain_val = GAIN_UNITY;
        2: gain_val = GAIN_MAX;
        3: gain_val = $urandom_range(0, 65536);
        default: gain_val = $urandom_range(0, 131071);
      endcase
      write_reg(CFG_WAVEFORM, ($urandom() & ~32'h3) | 32'(wave_sel));
      write_reg(CFG_PHASE_STEP, step_val);
      write_reg(CFG_GAIN, ($urandom() & ~GAIN_MAX) | gain_val);
      for (i = 0; i < PHASE_TICKS; i++) begin
        // Long receiver hold-off while the sender keeps offering ticks.
        if (ph == 4 && i == 10) begin
          hold_asked++;
        end
        // Sender pauses until the pipeline is empty.
        if (ph == 9 && i == 40) begin
          drain_results;
        end
        send_tick($urandom_range(19) == 0, 1'b0, 16'sd0);
      end
    end

    drain_results;
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
